/* src/fsq_pkg.sv */
package fsq_pkg;

  localparam logic [31:0] GuessMagic  = 32'h5f3759df;
  localparam logic [31:0] OneHalf     = 32'h3F000000;
  localparam logic [31:0] ThreeHalves = 32'h3FC00000;
  localparam logic [31:0] CanonNan    = 32'h7FC00000;
  localparam logic [31:0] InfBits     = 32'h7F800000;

  // cycles from an accepted request to its done strobe
  localparam int Lat = 11;

  // classified multiplier operands and product, passed between stages
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        sign;
    logic [9:0]  exp;       // xa + xb, biased twice
    logic [47:0] prod;
  } mul_mid_t;

  // unpacked rounding request: value = sig * 2^(e2), sig nonzero
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        sign;
    logic signed [11:0] e2;
    logic [63:0] sig;
  } rnd_req_t;

  function automatic logic is_nan(input logic [31:0] v);
    return v[30:0] > InfBits[30:0];
  endfunction

  // leading-one position of a 64-bit value (0 if none)
  function automatic logic [5:0] lead_one(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = i[5:0];
    end
    return p;
  endfunction

  // normalize and round to single, nearest even
  function automatic logic [31:0] round_pack(input rnd_req_t r);
    logic [5:0]  lz;
    logic [63:0] sig;
    logic signed [12:0] be;
    logic [6:0]  shift;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] bits;
    logic [31:0] s;
    lz = lead_one(r.sig);
    sig = r.sig << (6'd63 - lz);
    // leading one now at bit 63
    be = 13'(r.e2) + 13'(lz) + 13'sd127;
    s = {r.sign, 31'b0};
    if (r.special) return r.special_val;
    if (be >= 13'sd255) return s | InfBits;
    if (be >= 13'sd1) shift = 7'd40;
    else if (be < -13'sd23) return s;
    else shift = 7'(13'sd41 - be);
    kept = sig >> shift;
    rem  = sig & ((64'd1 << shift) - 64'd1);
    half = 64'd1 << (shift - 7'd1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (be <= 13'sd0) bits = kept[31:0];
    else bits = {be[8:0] - 9'd1, 23'b0} + kept[31:0];
    if (bits >= InfBits) return s | InfBits;
    return s | bits;
  endfunction

  // multiplier front end: specials and significand product
  function automatic mul_mid_t mul_front(input logic [31:0] a, input logic [31:0] b);
    mul_mid_t m;
    logic [7:0] ea;
    logic [7:0] eb;
    ea = a[30:23];
    eb = b[30:23];
    m.sign = a[31] ^ b[31];
    m.special = 1'b1;
    m.special_val = {m.sign, 31'b0};
    m.exp = 10'((ea == 0) ? 8'd1 : ea) + 10'((eb == 0) ? 8'd1 : eb);
    m.prod = {24'b0, (ea != 0), a[22:0]} * {24'b0, (eb != 0), b[22:0]};
    if (is_nan(a) || is_nan(b)) m.special_val = CanonNan;
    else if (ea == 8'hFF || eb == 8'hFF) begin
      if (a[30:0] == 0 || b[30:0] == 0) m.special_val = CanonNan;
      else m.special_val = {m.sign, InfBits[30:0]};
    end else if (!(a[30:0] == 0 || b[30:0] == 0)) m.special = 1'b0;
    return m;
  endfunction

  function automatic rnd_req_t mul_req(input mul_mid_t m);
    rnd_req_t r;
    r.special = m.special;
    r.special_val = m.special_val;
    r.sign = m.sign;
    r.e2 = 12'(m.exp) - 12'sd300;
    r.sig = {16'b0, m.prod};
    return r;
  endfunction

  // adder front end: specials, alignment and add/sub
  function automatic rnd_req_t add_req(input logic [31:0] ai, input logic [31:0] bi);
    rnd_req_t r;
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0] xa;
    logic [7:0] xb;
    logic [7:0] diff;
    logic [63:0] aa;
    logic [63:0] bb;
    logic [63:0] bs;
    a = ai;
    b = bi;
    r.special = 1'b1;
    r.sign = 1'b0;
    r.special_val = '0;
    r.e2 = '0;
    r.sig = '0;
    xa = (a[30:23] == 0) ? 8'd1 : a[30:23];
    xb = (b[30:23] == 0) ? 8'd1 : b[30:23];
    if (xb > xa || (xb == xa && b[22:0] > a[22:0])) begin
      a = bi; b = ai;
      xa = (a[30:23] == 0) ? 8'd1 : a[30:23];
      xb = (b[30:23] == 0) ? 8'd1 : b[30:23];
    end
    aa = {26'b0, (a[30:23] != 0), a[22:0], 14'b0} << 24;
    bb = {26'b0, (b[30:23] != 0), b[22:0], 14'b0} << 24;
    diff = xa - xb;
    if (diff >= 8'd63) bs = 64'd1;
    else bs = (bb >> diff) | {63'b0, |(bb & ((64'd1 << diff) - 64'd1))};
    if (is_nan(ai) || is_nan(bi)) r.special_val = CanonNan;
    else if (ai[30:23] == 8'hFF && bi[30:23] == 8'hFF)
      r.special_val = (ai[31] == bi[31]) ? ai : CanonNan;
    else if (ai[30:23] == 8'hFF) r.special_val = ai;
    else if (bi[30:23] == 8'hFF) r.special_val = bi;
    else if (ai[30:0] == 0 && bi[30:0] == 0) r.special_val = {ai[31] & bi[31], 31'b0};
    else if (ai[30:0] == 0) r.special_val = bi;
    else if (bi[30:0] == 0) r.special_val = ai;
    else if (a[31] != b[31] && aa == bs) r.special_val = '0;
    else begin
      r.special = 1'b0;
      r.sign = a[31];
      r.e2 = 12'(xa) - 12'sd188;
      r.sig = (a[31] == b[31]) ? aa + bs : aa - bs;
    end
    return r;
  endfunction

endpackage

/* src/fsq_mul.sv */
// Two-stage single-precision multiplier: product, then round.
module fsq_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);
  fsq_pkg::mul_mid_t mid;

  always_ff @(posedge clk) begin
    mid <= fsq_pkg::mul_front(a, b);
    p   <= fsq_pkg::round_pack(fsq_pkg::mul_req(mid));
  end
endmodule

/* src/fsq_add.sv */
// Two-stage single-precision adder: align/add, then round.
module fsq_add (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] s
);
  fsq_pkg::rnd_req_t req;

  always_ff @(posedge clk) begin
    req <= fsq_pkg::add_req(a, b);
    s   <= fsq_pkg::round_pack(req);
  end
endmodule

/* src/fast_sqrt_single_newton_core.sv */
// Approximate square root of a single-precision value, one Newton step on the
// classic inverse-root guess. Fully pipelined: a request may be issued every
// cycle (busy stays low) and its root_bits appear with done after the input
// register, three multiplier passes, one adder and a final multiplier, two
// register stages each. The receiver cannot stall; each result is on root_bits
// for the single cycle that done is high.
module fast_sqrt_single_newton_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_bits,
  output logic        done,
  output logic [31:0] root_bits
);
  logic [fsq_pkg::Lat-1:0] vld;
  logic [31:0] x0, g0;
  logic [31:0] h, xg;             // stage 2 outputs
  logic [31:0] g1, g2, g3, g4;    // delays to align
  logic [31:0] hg, t, d, r;
  logic [31:0] xg_q [0:5];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[fsq_pkg::Lat-2:0], start};
  end

  always_ff @(posedge clk) begin
    x0 <= x_bits;
    g0 <= fsq_pkg::GuessMagic - {x_bits[31], x_bits[31:1]};
    g1 <= g0;
    g2 <= g1;
    g3 <= g2;
    g4 <= g3;
    xg_q[0] <= xg;
    for (int i = 1; i < 6; i++) xg_q[i] <= xg_q[i-1];
  end

  fsq_mul u_h  (.clk(clk), .a(fsq_pkg::OneHalf), .b(x0), .p(h));
  fsq_mul u_xg (.clk(clk), .a(x0), .b(g0), .p(xg));
  fsq_mul u_hg (.clk(clk), .a(h), .b(g2), .p(hg));
  fsq_mul u_t  (.clk(clk), .a(hg), .b(g4), .p(t));
  fsq_add u_d  (.clk(clk), .a(fsq_pkg::ThreeHalves), .b({~t[31], t[30:0]}), .s(d));
  fsq_mul u_r  (.clk(clk), .a(xg_q[5]), .b(d), .p(r));

  assign done = vld[fsq_pkg::Lat-1];
  assign root_bits = fsq_pkg::is_nan(r) ? fsq_pkg::CanonNan : r;
endmodule
